[hw/rtl/cartridge_bank_mapper_assert.svh]
// assertion macros used by the checker file
`ifndef CARTRIDGE_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbm assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbm assertion failed");

`endif

[hw/rtl/cbm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cbm_pkg;

  localparam int unsigned RAM_BANK_NUM_DEF = 4;
  localparam int unsigned RAM_BANK_BYTES   = 8192;
  localparam int unsigned ROM_BANK_BITS    = 5;
  localparam int unsigned RAM_OFF_BITS     = 13;
  localparam int unsigned ROM_OFF_BITS     = 14;
  localparam int unsigned ROM_ADDR_W       = ROM_BANK_BITS + ROM_OFF_BITS;
  localparam int unsigned RAM_IDX_W        = RAM_OFF_BITS + 2;

  // configuration register indexes
  localparam logic CFG_MAPPER_KIND    = 1'b0;
  localparam logic CFG_RAM_BANK_COUNT = 1'b1;

  // transaction commands
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // mapper kinds
  localparam logic [1:0] MK_NONE   = 2'd0;
  localparam logic [1:0] MK_BANKED = 2'd1;

  // address regions by bus_address[15:13]
  localparam logic [2:0] RGN_RAM_EN   = 3'd0;
  localparam logic [2:0] RGN_ROM_BANK = 3'd1;
  localparam logic [2:0] RGN_RAM_SEL  = 3'd2;
  localparam logic [2:0] RGN_MODE     = 3'd3;
  localparam logic [2:0] RGN_RAM      = 3'd5;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS   = 8'hFF;

  typedef struct packed {
    logic                  from_rom;
    logic [ROM_ADDR_W-1:0] rom_addr;
    logic                  ram_hit;
  } stage_t;

endpackage
`default_nettype wire

[hw/rtl/cbm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module cbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/cartridge_bank_mapper.sv]
// path: an accepted transaction is held in the s1 register, then in the output register
// throughput: one transaction per cycle while the output is taken; the registered
// read of the banked RAM sets the extra stage
// reset: asynchronous active low; mapper registers take their reset values at once,
// banked RAM is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module cartridge_bank_mapper
  import cbm_pkg::*;
#(
  parameter int unsigned RAM_BANK_NUM = RAM_BANK_NUM_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_index_i,
  input  wire logic [2:0]            cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  command_i,
  input  wire logic [15:0]           bus_address_i,
  input  wire logic [7:0]            write_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       from_rom_o,
  output logic [ROM_ADDR_W-1:0]      rom_byte_address_o,
  output logic [7:0]                 read_byte_o
);

  localparam int unsigned MEM_DEPTH = RAM_BANK_NUM * RAM_BANK_BYTES;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  logic [1:0] kind_q;
  logic [2:0] bank_cnt_q;
  logic       ram_en_q, ram_en_d;
  logic [ROM_BANK_BITS-1:0] rom_bank_q, rom_bank_d;
  logic [1:0] sel_q, sel_d;
  logic       mode_q, mode_d;
  logic [1:0] active_q, active_d;

  logic       s1_valid_q, out_valid_q;
  stage_t     s1_q, s1_d;
  logic       s1_adv, in_acc;
  logic       from_rom_q;
  logic [ROM_ADDR_W-1:0] rom_addr_q;
  logic [7:0] read_byte_q;

  logic [2:0] present_cnt;
  logic       present, banked, ram_acc, ram_we, ram_re;
  logic [2:0] region;
  logic [7:0] bank_byte;
  logic [RAM_IDX_W-1:0] ram_idx;
  logic [7:0] ram_rdata;

  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign region  = bus_address_i[15:13];
  assign banked  = (kind_q == MK_BANKED);
  assign ram_idx = {active_q, bus_address_i[RAM_OFF_BITS-1:0]};

  always_comb begin
    present_cnt = bank_cnt_q;
    if (present_cnt > 3'(RAM_BANK_NUM)) begin
      present_cnt = 3'(RAM_BANK_NUM);
    end
    present = ({1'b0, active_q} < present_cnt);
  end

  assign ram_acc = in_acc & banked & (region == RGN_RAM) & ram_en_q & present;
  assign ram_we  = ram_acc & (command_i == CMD_WRITE);
  assign ram_re  = ram_acc & (command_i == CMD_READ);

  cbm_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_idx[MEM_AW-1:0]),
    .wdata_i (write_byte_i),
    .rdata_o (ram_rdata)
  );

  // control register writes
  always_comb begin
    ram_en_d   = ram_en_q;
    rom_bank_d = rom_bank_q;
    sel_d      = sel_q;
    mode_d     = mode_q;
    active_d   = active_q;
    bank_byte  = (write_byte_i == 8'd0) ? 8'd1 : write_byte_i;
    if (in_acc && banked && command_i == CMD_WRITE) begin
      case (region)
        RGN_RAM_EN: begin
          ram_en_d = (write_byte_i[3:0] == RAM_EN_KEY);
        end
        RGN_ROM_BANK: begin
          rom_bank_d = bank_byte[ROM_BANK_BITS-1:0];
        end
        RGN_RAM_SEL: begin
          sel_d = write_byte_i[1:0];
          if (mode_q) begin
            active_d = write_byte_i[1:0];
          end
        end
        RGN_MODE: begin
          mode_d = write_byte_i[0];
          if (write_byte_i[0]) begin
            active_d = sel_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // read result ahead of the ram data
  always_comb begin
    s1_d = '0;
    if (command_i == CMD_READ) begin
      if (kind_q == MK_NONE) begin
        if (!bus_address_i[15]) begin
          s1_d.from_rom = 1'b1;
          s1_d.rom_addr = ROM_ADDR_W'(bus_address_i);
        end
      end else if (banked) begin
        if (!bus_address_i[15]) begin
          s1_d.from_rom = 1'b1;
          if (bus_address_i[14]) begin
            s1_d.rom_addr = {rom_bank_q, bus_address_i[ROM_OFF_BITS-1:0]};
          end else begin
            s1_d.rom_addr = ROM_ADDR_W'(bus_address_i);
          end
        end
        s1_d.ram_hit = ram_re;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= MK_NONE;
      bank_cnt_q  <= 3'd0;
      ram_en_q    <= 1'b0;
      rom_bank_q  <= ROM_BANK_BITS'(1);
      sel_q       <= 2'd0;
      mode_q      <= 1'b0;
      active_q    <= 2'd0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MAPPER_KIND:    kind_q     <= cfg_data_i[1:0];
          CFG_RAM_BANK_COUNT: bank_cnt_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      ram_en_q   <= ram_en_d;
      rom_bank_q <= rom_bank_d;
      sel_q      <= sel_d;
      mode_q     <= mode_d;
      active_q   <= active_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      from_rom_q  <= s1_q.from_rom;
      rom_addr_q  <= s1_q.rom_addr;
      read_byte_q <= s1_q.ram_hit ? ram_rdata : OPEN_BUS;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign from_rom_o         = from_rom_q;
  assign rom_byte_address_o = rom_addr_q;
  assign read_byte_o        = read_byte_q;

endmodule
`default_nettype wire

[hw/rtl/cbm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "cartridge_bank_mapper_assert.svh"
module cbm_checker
  import cbm_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic                  from_rom_o,
  input wire logic [ROM_ADDR_W-1:0] rom_byte_address_o,
  input wire logic [7:0]            read_byte_o
);

  `CBM_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `CBM_ASSERT_IMP(a_rom_open_bus, out_valid_o && from_rom_o, read_byte_o == OPEN_BUS)
  `CBM_ASSERT_IMP(a_no_rom_addr, out_valid_o && !from_rom_o, rom_byte_address_o == '0)
  `CBM_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .from_rom_o         (from_rom_o),
  .rom_byte_address_o (rom_byte_address_o),
  .read_byte_o        (read_byte_o)
);
`default_nettype wire
